// ===== rtl/core/jsu_pkg.sv =====
// Shared types, codes and helper functions for the JSON string unescape block.
package jsu_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_req;
		logic       source_end;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [3:0] error_code;
		logic       last;
	} out_word_t;

	localparam int MaxResults = 4;

	// results of one input word, item 0 goes out first
	typedef struct packed {
		logic [2:0]                      cnt;
		out_word_t [MaxResults-1:0]      item;
	} res_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BODY,
		PH_ESC,
		PH_HEX1,
		PH_LOWBS,
		PH_LOWU,
		PH_HEX2
	} phase_t;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [3:0] ERR_NONE         = 4'd0;
	localparam logic [3:0] ERR_CONTROL      = 4'd1;
	localparam logic [3:0] ERR_TRUNC_ESC    = 4'd2;
	localparam logic [3:0] ERR_BAD_ESC      = 4'd3;
	localparam logic [3:0] ERR_TRUNC_UNI    = 4'd4;
	localparam logic [3:0] ERR_BAD_HEX      = 4'd5;
	localparam logic [3:0] ERR_MISSING_LOW  = 4'd6;
	localparam logic [3:0] ERR_BAD_LOW      = 4'd7;
	localparam logic [3:0] ERR_STRAY_LOW    = 4'd8;
	localparam logic [3:0] ERR_UNTERMINATED = 4'd9;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CTRL_LIM = 8'h20;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic [2:0]       cnt;
		logic [3:0][7:0]  b;
	} utf8_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t r;
		r = '0;
		if (c inside {[8'h30:8'h39]}) begin
			r.ok  = 1'b1;
			r.val = 4'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			r.ok  = 1'b1;
			r.val = 4'(c - 8'h57);
		end else if (c inside {[8'h41:8'h46]}) begin
			r.ok  = 1'b1;
			r.val = 4'(c - 8'h37);
		end
		return r;
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp <= 21'h7f) begin
			r.cnt  = 3'd1;
			r.b[0] = cp[7:0];
		end else if (cp <= 21'h7ff) begin
			r.cnt  = 3'd2;
			r.b[0] = 8'hc0 | {3'b000, cp[10:6]};
			r.b[1] = 8'h80 | {2'b00, cp[5:0]};
		end else if (cp <= 21'hffff) begin
			r.cnt  = 3'd3;
			r.b[0] = 8'he0 | {4'b0000, cp[15:12]};
			r.b[1] = 8'h80 | {2'b00, cp[11:6]};
			r.b[2] = 8'h80 | {2'b00, cp[5:0]};
		end else begin
			r.cnt  = 3'd4;
			r.b[0] = 8'hf0 | {5'b00000, cp[20:18]};
			r.b[1] = 8'h80 | {2'b00, cp[17:12]};
			r.b[2] = 8'h80 | {2'b00, cp[11:6]};
			r.b[3] = 8'h80 | {2'b00, cp[5:0]};
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescape to UTF-8 block.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+-------------------------------------------
//  source  | src_valid | src_stall | src_data: data_byte, start_req, source_end
//  result  | dst_valid | dst_stall | dst_data: out_byte, kind, error_code, last
//
// Each source byte is decoded in the cycle it is taken; its results appear on
// dst the next cycle. A byte making N results (N up to 4, a long UTF-8 sequence)
// holds the source while the result register drains one word a cycle when dst does
// not stall; bytes with zero or one result flow at one per cycle unless dst stalls.
// Reset clears the parse state to idle and empties the result register.
module json_string_unescape_utf8 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  jsu_pkg::in_word_t  src_data,
	output logic               dst_valid,
	input  logic               dst_stall,
	output jsu_pkg::out_word_t dst_data
);

	logic          accept;
	jsu_pkg::res_t res;

	assign accept = src_valid && !src_stall;

	jsu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.word   (src_data),
		.res    (res)
	);

	jsu_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res       (res),
		.busy      (src_stall),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

endmodule

// ===== rtl/core/jsu_decode.sv =====
// Escape decoder: parse state registers and the per-byte result builder.
module jsu_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  jsu_pkg::in_word_t word,
	output jsu_pkg::res_t     res
);

	jsu_pkg::phase_t phase_q, ph, ph_d;
	logic [1:0]  dc_q, dc, dc_d;
	logic [15:0] cu_q, cu, cu_d;
	logic [9:0]  hs_q, hs, hs_d;

	logic        err_en;
	logic [3:0]  err_v;
	logic        close_en;
	logic        data_en;
	logic [7:0]  data_v;
	logic        cp_en;
	logic [20:0] cp;
	logic [10:0] plane;
	logic [7:0]  c;
	jsu_pkg::hex_t  hv;
	jsu_pkg::utf8_t u;

	assign c  = word.data_byte;
	assign hv = jsu_pkg::hex_value(c);
	assign u  = jsu_pkg::utf8_encode(cp);

	always_comb begin
		// start clears everything before the byte is looked at
		ph = word.start_req ? jsu_pkg::PH_BODY : phase_q;
		dc = word.start_req ? 2'd0 : dc_q;
		cu = word.start_req ? 16'h0000 : cu_q;
		hs = word.start_req ? 10'h000 : hs_q;

		ph_d = ph;
		dc_d = dc;
		cu_d = cu;
		hs_d = hs;
		err_en   = 1'b0;
		err_v    = jsu_pkg::ERR_NONE;
		close_en = 1'b0;
		data_en  = 1'b0;
		data_v   = 8'h00;
		cp_en    = 1'b0;
		cp       = '0;
		plane    = {1'b0, hs} + 11'd64;

		if (word.source_end) begin
			case (ph)
				jsu_pkg::PH_BODY: begin
					err_en = 1'b1;
					err_v  = jsu_pkg::ERR_UNTERMINATED;
				end
				jsu_pkg::PH_ESC: begin
					err_en = 1'b1;
					err_v  = jsu_pkg::ERR_TRUNC_ESC;
				end
				jsu_pkg::PH_HEX1: begin
					err_en = 1'b1;
					err_v  = jsu_pkg::ERR_TRUNC_UNI;
				end
				jsu_pkg::PH_LOWBS, jsu_pkg::PH_LOWU, jsu_pkg::PH_HEX2: begin
					err_en = 1'b1;
					err_v  = jsu_pkg::ERR_MISSING_LOW;
				end
				default: ph_d = jsu_pkg::PH_IDLE;
			endcase
		end else begin
			case (ph)
				jsu_pkg::PH_BODY: begin
					if (c == jsu_pkg::CH_QUOTE) begin
						ph_d     = jsu_pkg::PH_IDLE;
						close_en = 1'b1;
					end else if (c < jsu_pkg::CTRL_LIM) begin
						err_en = 1'b1;
						err_v  = jsu_pkg::ERR_CONTROL;
					end else if (c == jsu_pkg::CH_BSL) begin
						ph_d = jsu_pkg::PH_ESC;
					end else begin
						data_en = 1'b1;
						data_v  = c;
					end
				end
				jsu_pkg::PH_ESC: begin
					ph_d    = jsu_pkg::PH_BODY;
					data_en = 1'b1;
					case (c)
						jsu_pkg::CH_QUOTE: data_v = 8'h22;
						jsu_pkg::CH_BSL:   data_v = 8'h5c;
						jsu_pkg::CH_SLASH: data_v = 8'h2f;
						jsu_pkg::CH_B:     data_v = 8'h08;
						jsu_pkg::CH_F:     data_v = 8'h0c;
						jsu_pkg::CH_N:     data_v = 8'h0a;
						jsu_pkg::CH_R:     data_v = 8'h0d;
						jsu_pkg::CH_T:     data_v = 8'h09;
						jsu_pkg::CH_U: begin
							data_en = 1'b0;
							ph_d    = jsu_pkg::PH_HEX1;
							dc_d    = 2'd0;
							cu_d    = 16'h0000;
						end
						default: begin
							data_en = 1'b0;
							err_en  = 1'b1;
							err_v   = jsu_pkg::ERR_BAD_ESC;
						end
					endcase
				end
				jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
					if (!hv.ok) begin
						err_en = 1'b1;
						err_v  = jsu_pkg::ERR_BAD_HEX;
					end else begin
						cu_d = {cu[11:0], hv.val};
						if (dc != 2'd3) begin
							dc_d = dc + 2'd1;
						end else begin
							dc_d = 2'd0;
							if (ph == jsu_pkg::PH_HEX1) begin
								if (cu_d inside {[16'hd800:16'hdbff]}) begin
									hs_d = cu_d[9:0];
									ph_d = jsu_pkg::PH_LOWBS;
								end else if (cu_d inside {[16'hdc00:16'hdfff]}) begin
									err_en = 1'b1;
									err_v  = jsu_pkg::ERR_STRAY_LOW;
								end else begin
									ph_d  = jsu_pkg::PH_BODY;
									cp_en = 1'b1;
									cp    = {5'b00000, cu_d};
								end
							end else begin
								if (!(cu_d inside {[16'hdc00:16'hdfff]})) begin
									err_en = 1'b1;
									err_v  = jsu_pkg::ERR_BAD_LOW;
								end else begin
									// 0x10000 + (high << 10) + low offset
									ph_d  = jsu_pkg::PH_BODY;
									cp_en = 1'b1;
									cp    = {plane, cu_d[9:0]};
								end
							end
						end
					end
				end
				jsu_pkg::PH_LOWBS: begin
					if (c == jsu_pkg::CH_BSL) begin
						ph_d = jsu_pkg::PH_LOWU;
					end else begin
						err_en = 1'b1;
						err_v  = jsu_pkg::ERR_MISSING_LOW;
					end
				end
				jsu_pkg::PH_LOWU: begin
					if (c == jsu_pkg::CH_U) begin
						ph_d = jsu_pkg::PH_HEX2;
						dc_d = 2'd0;
						cu_d = 16'h0000;
					end else begin
						err_en = 1'b1;
						err_v  = jsu_pkg::ERR_MISSING_LOW;
					end
				end
				default: ph_d = jsu_pkg::PH_IDLE;
			endcase
		end

		if (err_en) begin
			ph_d = jsu_pkg::PH_IDLE;
		end
	end

	always_comb begin
		res = '0;
		if (err_en) begin
			res.cnt                = 3'd1;
			res.item[0].kind       = jsu_pkg::KIND_ERROR;
			res.item[0].error_code = err_v;
		end else if (close_en) begin
			res.cnt          = 3'd1;
			res.item[0].kind = jsu_pkg::KIND_CLOSE;
		end else if (data_en) begin
			res.cnt              = 3'd1;
			res.item[0].kind     = jsu_pkg::KIND_DATA;
			res.item[0].out_byte = data_v;
		end else if (cp_en) begin
			res.cnt = u.cnt;
			for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
				res.item[i].kind     = jsu_pkg::KIND_DATA;
				res.item[i].out_byte = u.b[i];
			end
		end
		if (res.cnt != 3'd0) begin
			res.item[2'(res.cnt - 3'd1)].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jsu_pkg::PH_IDLE;
			dc_q    <= 2'd0;
			cu_q    <= 16'h0000;
			hs_q    <= 10'h000;
		end else if (accept) begin
			phase_q <= ph_d;
			dc_q    <= dc_d;
			cu_q    <= cu_d;
			hs_q    <= hs_d;
		end
	end

endmodule

// ===== rtl/core/jsu_emit.sv =====
// Result register: holds up to four results of one byte and sends them one a cycle while dst does not stall.
module jsu_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  jsu_pkg::res_t      res,
	output logic               busy,
	output logic               dst_valid,
	input  logic               dst_stall,
	output jsu_pkg::out_word_t dst_data
);

	jsu_pkg::out_word_t [jsu_pkg::MaxResults-1:0] buf_q;
	logic [2:0] cnt_q;
	logic       take;

	assign dst_valid = (cnt_q != 3'd0);
	assign dst_data  = buf_q[0];
	assign take      = dst_valid && !dst_stall;
	// a new byte may come in when nothing is held or the last held word leaves this cycle
	assign busy      = (cnt_q > 3'd1) || ((cnt_q == 3'd1) && dst_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= res.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res.item;
		end else if (take) begin
			for (int i = 0; i < jsu_pkg::MaxResults - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

endmodule

// ===== dv/tb_json_string_unescape_utf8.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the JSON string unescape to UTF-8 block.
module tb_json_string_unescape_utf8;

	localparam int WatchdogLimit = 3000;
	localparam int RxHoldCycles  = 200;
	localparam int RandomItems   = 70;
	localparam int MaxReported   = 10;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               src_valid;
	logic               src_stall;
	jsu_pkg::in_word_t  src_data;
	logic               dst_valid;
	logic               dst_stall;
	jsu_pkg::out_word_t dst_data;

	json_string_unescape_utf8 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

	always #5 clk = ~clk;

	// decoder state mirrored by the testbench
	jsu_pkg::phase_t dec_phase;
	logic [1:0]      dec_digits;
	logic [15:0]     dec_unit;
	logic [9:0]      dec_high;

	jsu_pkg::out_word_t decoded_q[$];
	jsu_pkg::out_word_t step_words[$];

	int   live_items   = 0;
	int   results_seen = 0;
	int   closes_seen  = 0;
	int   errors_seen  = 0;
	int   mismatches   = 0;
	int   idle_cycles  = 0;
	logic start_next   = 1'b0;
	logic src_burst    = 1'b0;
	logic rx_quiet     = 1'b0;
	logic rx_hold_req  = 1'b0;

	function automatic void emit(input logic [7:0] b, input logic [1:0] k,
		input logic [3:0] e);
		jsu_pkg::out_word_t w;
		w.out_byte   = b;
		w.kind       = k;
		w.error_code = e;
		w.last       = 1'b0;
		step_words   = {step_words, w};
	endfunction

	function automatic void decode_fault(input logic [3:0] e);
		dec_phase = jsu_pkg::PH_IDLE;
		emit(8'h00, jsu_pkg::KIND_ERROR, e);
	endfunction

	function automatic void emit_utf8(input logic [20:0] cp);
		if (cp < 21'h80) begin
			emit(cp[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
		end else if (cp < 21'h800) begin
			emit({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
		end else if (cp < 21'h10000) begin
			emit({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			emit({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
		end else begin
			emit({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			emit({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			emit({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
		end
	endfunction

	// bit 4 set marks a valid hex digit
	function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
		if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
		if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
		return 5'h00;
	endfunction

	function automatic logic is_escape_char(input logic [7:0] c);
		return c inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH,
			jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R,
			jsu_pkg::CH_T, jsu_pkg::CH_U};
	endfunction

	// expected result words for one accepted source word
	function automatic void unescape_word(input jsu_pkg::in_word_t w);
		logic [4:0]         hv;
		logic [20:0]        cp;
		jsu_pkg::out_word_t ow;
		step_words.delete();
		if (w.start_req || dec_phase != jsu_pkg::PH_IDLE) live_items++;
		if (w.start_req) begin
			dec_phase  = jsu_pkg::PH_BODY;
			dec_digits = '0;
			dec_unit   = '0;
			dec_high   = '0;
		end
		if (w.source_end) begin
			case (dec_phase)
				jsu_pkg::PH_BODY: decode_fault(jsu_pkg::ERR_UNTERMINATED);
				jsu_pkg::PH_ESC:  decode_fault(jsu_pkg::ERR_TRUNC_ESC);
				jsu_pkg::PH_HEX1: decode_fault(jsu_pkg::ERR_TRUNC_UNI);
				jsu_pkg::PH_LOWBS, jsu_pkg::PH_LOWU, jsu_pkg::PH_HEX2:
					decode_fault(jsu_pkg::ERR_MISSING_LOW);
				default: dec_phase = jsu_pkg::PH_IDLE;
			endcase
		end else begin
			case (dec_phase)
				jsu_pkg::PH_BODY: begin
					if (w.data_byte == jsu_pkg::CH_QUOTE) begin
						dec_phase = jsu_pkg::PH_IDLE;
						emit(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE);
					end else if (w.data_byte < jsu_pkg::CTRL_LIM) begin
						decode_fault(jsu_pkg::ERR_CONTROL);
					end else if (w.data_byte == jsu_pkg::CH_BSL) begin
						dec_phase = jsu_pkg::PH_ESC;
					end else begin
						emit(w.data_byte, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
					end
				end
				jsu_pkg::PH_ESC: begin
					dec_phase = jsu_pkg::PH_BODY;
					case (w.data_byte)
						jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH:
							emit(w.data_byte, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
						jsu_pkg::CH_B: emit(8'h08, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
						jsu_pkg::CH_F: emit(8'h0c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
						jsu_pkg::CH_N: emit(8'h0a, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
						jsu_pkg::CH_R: emit(8'h0d, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
						jsu_pkg::CH_T: emit(8'h09, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
						jsu_pkg::CH_U: begin
							dec_phase  = jsu_pkg::PH_HEX1;
							dec_digits = '0;
							dec_unit   = '0;
						end
						default: decode_fault(jsu_pkg::ERR_BAD_ESC);
					endcase
				end
				jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
					hv = hex_digit_value(w.data_byte);
					if (!hv[4]) begin
						decode_fault(jsu_pkg::ERR_BAD_HEX);
					end else begin
						dec_unit = {dec_unit[11:0], hv[3:0]};
						if (dec_digits != 2'd3) begin
							dec_digits++;
						end else begin
							dec_digits = '0;
							if (dec_phase == jsu_pkg::PH_HEX1) begin
								if (dec_unit >= 16'hd800 && dec_unit <= 16'hdbff) begin
									dec_high  = dec_unit[9:0];
									dec_phase = jsu_pkg::PH_LOWBS;
								end else if (dec_unit >= 16'hdc00 && dec_unit <= 16'hdfff) begin
									decode_fault(jsu_pkg::ERR_STRAY_LOW);
								end else begin
									dec_phase = jsu_pkg::PH_BODY;
									emit_utf8({5'b0, dec_unit});
								end
							end else if (dec_unit < 16'hdc00 || dec_unit > 16'hdfff) begin
								decode_fault(jsu_pkg::ERR_BAD_LOW);
							end else begin
								dec_phase = jsu_pkg::PH_BODY;
								cp = 21'h10000 + {1'b0, dec_high, dec_unit[9:0]};
								emit_utf8(cp);
							end
						end
					end
				end
				jsu_pkg::PH_LOWBS: begin
					if (w.data_byte == jsu_pkg::CH_BSL) dec_phase = jsu_pkg::PH_LOWU;
					else decode_fault(jsu_pkg::ERR_MISSING_LOW);
				end
				jsu_pkg::PH_LOWU: begin
					if (w.data_byte == jsu_pkg::CH_U) begin
						dec_phase  = jsu_pkg::PH_HEX2;
						dec_digits = '0;
						dec_unit   = '0;
					end else begin
						decode_fault(jsu_pkg::ERR_MISSING_LOW);
					end
				end
				default: dec_phase = jsu_pkg::PH_IDLE;
			endcase
		end
		foreach (step_words[i]) begin
			ow        = step_words[i];
			ow.last   = (i == step_words.size() - 1);
			decoded_q = {decoded_q, ow};
		end
	endfunction

	function automatic int pick_src_gap();
		int r;
		if (src_burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	task automatic send_word(input jsu_pkg::in_word_t w);
		int gap;
		src_valid <= 1'b1;
		src_data  <= w;
		@(posedge clk);
		while (!(src_valid && !src_stall)) @(posedge clk);
		unescape_word(w);
		gap = pick_src_gap();
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_item(input logic [7:0] b, input logic endf);
		jsu_pkg::in_word_t w;
		w.data_byte  = b;
		w.start_req  = start_next;
		w.source_end = endf;
		start_next   = 1'b0;
		send_word(w);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(b, 1'b0);
	endtask

	// no byte travels with an end word, so its data is random
	task automatic send_end();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'("0" + n);
		if ($urandom_range(0, 1)) return 8'("a" + n - 4'd10);
		return 8'("A" + n - 4'd10);
	endfunction

	task automatic send_quad(input logic [15:0] v);
		send_byte(jsu_pkg::CH_BSL);
		send_byte(jsu_pkg::CH_U);
		for (int i = 3; i >= 0; i--) send_byte(hex_char(v[i*4 +: 4]));
	endtask

	function automatic logic [15:0] random_high();
		return 16'hd800 | 16'($urandom_range(0, 1023));
	endfunction

	function automatic logic [15:0] random_low();
		return 16'hdc00 | 16'($urandom_range(0, 1023));
	endfunction

	task automatic wait_drained();
		src_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one well-formed piece of string content
	task automatic send_token();
		int          r;
		logic [7:0]  c;
		logic [15:0] v;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			do c = 8'($urandom_range(32, 255));
			while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSL);
			send_byte(c);
		end else if (r < 65) begin
			do c = 8'($urandom_range(32, 127));
			while (!is_escape_char(c) || c == jsu_pkg::CH_U);
			send_byte(jsu_pkg::CH_BSL);
			send_byte(c);
		end else if (r < 82) begin
			case ($urandom_range(0, 2))
				0: v = 16'($urandom_range(0, 16'h7f));
				1: v = 16'($urandom_range(16'h80, 16'h7ff));
				default: begin
					do v = 16'($urandom_range(16'h800, 16'hffff));
					while (v >= 16'hd800 && v <= 16'hdfff);
				end
			endcase
			send_quad(v);
		end else begin
			send_quad(random_high());
			send_quad(random_low());
		end
	endtask

	// a broken tail: every fault the decoder reports, plus raw noise
	task automatic send_fault();
		int          k;
		int          sel;
		logic [7:0]  c;
		logic [15:0] v;
		sel = $urandom_range(0, 9);
		case (sel)
			0: send_byte(8'($urandom_range(0, 31)));
			1: send_end();
			2: begin
				send_byte(jsu_pkg::CH_BSL);
				send_end();
			end
			3: begin
				do c = 8'($urandom_range(0, 255)); while (is_escape_char(c));
				send_byte(jsu_pkg::CH_BSL);
				send_byte(c);
			end
			4, 5: begin
				send_byte(jsu_pkg::CH_BSL);
				send_byte(jsu_pkg::CH_U);
				k = $urandom_range(0, 3);
				repeat (k) send_byte(hex_char(4'($urandom_range(0, 15))));
				if (sel == 4) begin
					send_end();
				end else begin
					do c = 8'($urandom_range(0, 255)); while (hex_digit_value(c) >= 5'h10);
					send_byte(c);
				end
			end
			6: send_quad(random_low());
			7: begin
				send_quad(random_high());
				case ($urandom_range(0, 4))
					0: begin
						do c = 8'($urandom_range(0, 255)); while (c == jsu_pkg::CH_BSL);
						send_byte(c);
					end
					1: begin
						do c = 8'($urandom_range(0, 255)); while (c == jsu_pkg::CH_U);
						send_byte(jsu_pkg::CH_BSL);
						send_byte(c);
					end
					2: send_end();
					3: begin
						send_byte(jsu_pkg::CH_BSL);
						send_end();
					end
					default: begin
						send_byte(jsu_pkg::CH_BSL);
						send_byte(jsu_pkg::CH_U);
						k = $urandom_range(0, 3);
						repeat (k) send_byte(hex_char(4'($urandom_range(0, 15))));
						send_end();
					end
				endcase
			end
			8: begin
				send_quad(random_high());
				do v = 16'($urandom); while (v >= 16'hdc00 && v <= 16'hdfff);
				send_quad(v);
			end
			default: begin
				repeat ($urandom_range(2, 8)) begin
					start_next = ($urandom_range(0, 9) == 0);
					send_item(8'($urandom_range(0, 255)), $urandom_range(0, 6) == 0);
				end
			end
		endcase
	endtask

	task automatic send_string(input int max_tokens);
		start_next = 1'b1;
		repeat ($urandom_range(0, max_tokens)) send_token();
		if ($urandom_range(0, 99) < 78) send_byte(jsu_pkg::CH_QUOTE);
		else send_fault();
		// words between strings are dropped by an idle decoder
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)),
				$urandom_range(0, 3) == 0);
		end
	endtask

	task automatic test_idle_input();
		send_byte("x");
		send_end();
	endtask

	task automatic test_start_with_end();
		start_next = 1'b1;
		send_end();
	endtask

	task automatic test_extreme_code_points();
		start_next = 1'b1;
		send_byte(jsu_pkg::CTRL_LIM);
		send_byte(8'hff);
		send_quad(16'hdbff);
		send_quad(16'hdfff);
		send_byte(jsu_pkg::CH_QUOTE);
	endtask

	task automatic test_truncation();
		start_next = 1'b1;
		send_byte(jsu_pkg::CH_BSL);
		send_end();
		start_next = 1'b1;
		send_byte(jsu_pkg::CH_BSL);
		send_byte(jsu_pkg::CH_U);
		send_byte("A");
		send_end();
	endtask

	task automatic test_missing_low();
		start_next = 1'b1;
		send_quad(16'hd800);
		send_byte("z");
	endtask

	// receiver blocks while surrogate pairs pile up four words each
	task automatic test_receiver_hold();
		rx_hold_req = 1'b1;
		start_next  = 1'b1;
		repeat (3) begin
			send_quad(random_high());
			send_quad(random_low());
		end
		send_byte(jsu_pkg::CH_QUOTE);
		wait_drained();
	endtask

	task automatic test_back_to_back();
		src_burst = 1'b1;
		rx_quiet  = 1'b1;
		repeat (3) send_string(6);
		src_burst = 1'b0;
		rx_quiet  = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_strings();
		int target;
		target = live_items + RandomItems;
		while (live_items < target) send_string(8);
		wait_drained();
	endtask

	// receiver stall pattern and the requested long hold-off
	initial begin
		int r;
		int len;
		dst_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				dst_stall <= 1'b1;
				repeat (RxHoldCycles) @(posedge clk);
			end
			if (rx_quiet) begin
				dst_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					dst_stall <= 1'b0;
				end else begin
					dst_stall <= 1'b1;
					len = (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
					repeat (len - 1) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		jsu_pkg::out_word_t exp_w;
		if (arst_n && dst_valid && !dst_stall) begin
			results_seen++;
			if (dst_data.kind == jsu_pkg::KIND_CLOSE) closes_seen++;
			if (dst_data.kind == jsu_pkg::KIND_ERROR) errors_seen++;
			if (decoded_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReported)
					$display("unexpected word: byte %h kind %0d err %0d last %0d",
						dst_data.out_byte, dst_data.kind, dst_data.error_code, dst_data.last);
			end else begin
				exp_w = decoded_q.pop_front();
				if (dst_data.out_byte !== exp_w.out_byte || dst_data.kind !== exp_w.kind ||
				    dst_data.error_code !== exp_w.error_code || dst_data.last !== exp_w.last) begin
					mismatches++;
					if (mismatches <= MaxReported)
						$display("word %0d: exp byte %h kind %0d err %0d last %0d",
							results_seen, exp_w.out_byte, exp_w.kind, exp_w.error_code,
							exp_w.last, ", got byte %h kind %0d err %0d last %0d",
							dst_data.out_byte, dst_data.kind,
							dst_data.error_code, dst_data.last);
				end
			end
		end
	end

	// no word moving on either side for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (dst_valid && !dst_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("timeout with %0d words outstanding", decoded_q.size());
			$display("json_string_unescape_utf8: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		src_valid  = 1'b0;
		src_data   = '0;
		dec_phase  = jsu_pkg::PH_IDLE;
		dec_digits = '0;
		dec_unit   = '0;
		dec_high   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_input();
		test_start_with_end();
		test_extreme_code_points();
		test_truncation();
		test_missing_low();
		wait_drained();
		test_receiver_hold();
		test_back_to_back();
		test_random_strings();

		wait_drained();
		repeat (16) @(posedge clk);
		$display("decoded %0d source words into %0d result words: %0d closes, %0d errors",
			live_items, results_seen, closes_seen, errors_seen);
		$display("%0d mismatches, %0d expected words never arrived",
			mismatches, decoded_q.size());
		if (mismatches == 0 && decoded_q.size() == 0)
			$display("json_string_unescape_utf8: match");
		else
			$display("json_string_unescape_utf8: mismatch");
		$finish;
	end

endmodule
